### hdl/rcpd_pkg.sv
// Shared types and constants for the RC PWM pulse decoder.
package rcpd_pkg;

    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int WIDTH_BITS = 16;
    localparam int CMD_BITS = 16;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // Quotient bits kept by the divider; anything at or above 2^17 saturates.
    localparam int QUOT_BITS = 17;
    localparam int DIVIDEND_BITS = 32;
    localparam int FRAC_SHIFT = 15;

    localparam logic [WIDTH_BITS-1:0] Q_ONE = 16'd16384;
    localparam logic [WIDTH_BITS-1:0] Q_SPAN = 16'd32768;

    localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RST = 16'd900;
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RST = 16'd2100;
    localparam logic [WIDTH_BITS-1:0] FAILSAFE_RST = 16'd800;
    localparam logic [WIDTH_BITS-1:0] MAP_LOW_RST = 16'd1000;
    localparam logic [WIDTH_BITS-1:0] MAP_HIGH_RST = 16'd2000;

    typedef enum logic [2:0] {
        CFG_MIN_WIDTH = 3'd0,
        CFG_MAX_WIDTH = 3'd1,
        CFG_FAILSAFE  = 3'd2,
        CFG_MAP_LOW   = 3'd3,
        CFG_MAP_HIGH  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START0,
        ST_WAIT0,
        ST_START1,
        ST_WAIT1,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 done;
        logic                 ovf;
        logic [QUOT_BITS-1:0] quot;
    } div_result_t;

endpackage

### hdl/rcpd_if.sv
// Valid/ready channel interfaces for decoder input events and output commands.
interface rcpd_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic        channel;
    logic        pin_level;
    logic [15:0] timestamp;

    modport source (output valid, mode, channel, pin_level, timestamp, input ready);
    modport sink (input valid, mode, channel, pin_level, timestamp, output ready);
endinterface

interface rcpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] throttle;
    logic signed [15:0] steer;
    logic               present_one;
    logic               present_two;
    logic               failsafe_one;
    logic               failsafe_two;

    modport source (output valid, throttle, steer, present_one, present_two,
                    failsafe_one, failsafe_two, input ready);
    modport sink (input valid, throttle, steer, present_one, present_two,
                  failsafe_one, failsafe_two, output ready);
endinterface

### hdl/rcpd_div.sv
// Restoring radix-2 divider that flags quotient overflow, one bit per cycle.
module rcpd_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [rcpd_pkg::DIVIDEND_BITS-1:0]   dividend,
    input  logic [rcpd_pkg::WIDTH_BITS-1:0]      divisor,
    output rcpd_pkg::div_result_t                result
);
    import rcpd_pkg::*;

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);
    localparam int HIGH_BITS = DIVIDEND_BITS - QUOT_BITS;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    ovf_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [WIDTH_BITS-1:0]   rem_reg;
    logic [WIDTH_BITS-1:0]   divisor_reg;
    logic [QUOT_BITS-1:0]    low_reg;
    logic [QUOT_BITS-1:0]    quot_reg;

    logic [WIDTH_BITS:0]     trial;
    logic                    fits;
    logic [WIDTH_BITS:0]     diff;

    assign trial = {rem_reg, low_reg[QUOT_BITS-1]};
    assign fits = trial >= {1'b0, divisor_reg};
    assign diff = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(QUOT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // If the top bits already reach the divisor the quotient cannot fit.
            rem_reg     <= WIDTH_BITS'(dividend[DIVIDEND_BITS-1 -: HIGH_BITS]);
            ovf_reg     <= WIDTH_BITS'(dividend[DIVIDEND_BITS-1 -: HIGH_BITS]) >= divisor;
            low_reg     <= dividend[QUOT_BITS-1:0];
            divisor_reg <= divisor;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
            low_reg  <= {low_reg[QUOT_BITS-2:0], 1'b0};
        end
    end

    assign result.done = done_reg;
    assign result.ovf  = ovf_reg;
    assign result.quot = quot_reg;

endmodule

### hdl/rc_pwm_pulse_decoder_top.sv
// Top level of the two-channel RC PWM pulse decoder with its APB register block.
//
// Each transaction on the input channel is a pin edge or a period tick and
// yields exactly one output transaction carrying both Q1.14 commands and the
// status bits. The two channel commands go one after the other through a
// single shared divider that produces one quotient bit per cycle. Each channel
// has a start state, then waits while the divider works through its quotient
// bits, and its command is stored when the divider reports done. Then the
// done state loads the output register, after which the next input can be
// accepted. The input channel is not ready while an item is in flight. If the
// previous result still waits in the output register, the item holds in its
// final step until that result is taken.
module rc_pwm_pulse_decoder_top #(
    parameter int COUNTER_BITS = rcpd_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rcpd_in_if.sink                             in_ch,
    rcpd_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcpd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [rcpd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [rcpd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import rcpd_pkg::*;

    // Timestamps are taken modulo the counter, but never wider than 16 bits.
    localparam int STAMP_BITS = (COUNTER_BITS < WIDTH_BITS) ? COUNTER_BITS : WIDTH_BITS;

    // Configuration registers.
    logic [WIDTH_BITS-1:0] min_width_reg;
    logic [WIDTH_BITS-1:0] max_width_reg;
    logic [WIDTH_BITS-1:0] failsafe_reg;
    logic [WIDTH_BITS-1:0] map_low_reg;
    logic [WIDTH_BITS-1:0] map_high_reg;
    logic [2:0]            reg_index;
    logic                  cfg_write;

    // Per-channel capture state.
    logic [STAMP_BITS-1:0] rise_stamp_reg [2];
    logic [WIDTH_BITS-1:0] pulse_width_reg [2];
    logic [1:0]            rise_seen_reg;
    logic [1:0]            received_reg;

    logic [STAMP_BITS-1:0] edge_stamp;
    logic [STAMP_BITS-1:0] edge_delta;

    // Sequencer.
    state_t state_reg;
    state_t state_next;
    logic   in_accept;
    logic   out_load;
    logic   div_start;
    logic   sel;
    logic   cmd_store;

    // Per-channel command datapath.
    logic [WIDTH_BITS-1:0]    sel_width;
    logic                     sel_recv;
    logic                     sel_fs;
    logic                     in_window;
    logic [WIDTH_BITS-1:0]    x_width;
    logic [WIDTH_BITS-1:0]    den;
    logic                     den_ok;
    logic                     num_pos;
    logic [WIDTH_BITS-1:0]    num_diff;
    logic [DIVIDEND_BITS-1:0] dividend;
    div_result_t              div_res;
    logic [WIDTH_BITS-1:0]    q_mag;
    logic signed [CMD_BITS-1:0] q_val;
    logic signed [CMD_BITS-1:0] cmd;
    logic signed [CMD_BITS-1:0] cmd_reg [2];

    logic out_valid_reg;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg <= MIN_WIDTH_RST;
            max_width_reg <= MAX_WIDTH_RST;
            failsafe_reg  <= FAILSAFE_RST;
            map_low_reg   <= MAP_LOW_RST;
            map_high_reg  <= MAP_HIGH_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                CFG_MIN_WIDTH: min_width_reg <= pwdata[WIDTH_BITS-1:0];
                CFG_MAX_WIDTH: max_width_reg <= pwdata[WIDTH_BITS-1:0];
                CFG_FAILSAFE:  failsafe_reg  <= pwdata[WIDTH_BITS-1:0];
                CFG_MAP_LOW:   map_low_reg   <= pwdata[WIDTH_BITS-1:0];
                CFG_MAP_HIGH:  map_high_reg  <= pwdata[WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            CFG_MIN_WIDTH: prdata = APB_DATA_BITS'(min_width_reg);
            CFG_MAX_WIDTH: prdata = APB_DATA_BITS'(max_width_reg);
            CFG_FAILSAFE:  prdata = APB_DATA_BITS'(failsafe_reg);
            CFG_MAP_LOW:   prdata = APB_DATA_BITS'(map_low_reg);
            CFG_MAP_HIGH:  prdata = APB_DATA_BITS'(map_high_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- capture
    assign in_accept  = in_ch.valid && in_ch.ready;
    assign edge_stamp = in_ch.timestamp[STAMP_BITS-1:0];
    assign edge_delta = edge_stamp - rise_stamp_reg[in_ch.channel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_stamp_reg[0]  <= '0;
            rise_stamp_reg[1]  <= '0;
            pulse_width_reg[0] <= '0;
            pulse_width_reg[1] <= '0;
            rise_seen_reg      <= '0;
            received_reg       <= '0;
        end
        else if (in_accept)
        begin
            if (!in_ch.mode)
            begin
                if (in_ch.pin_level)
                begin
                    rise_stamp_reg[in_ch.channel] <= edge_stamp;
                    rise_seen_reg[in_ch.channel]  <= 1'b1;
                end
                else
                begin
                    pulse_width_reg[in_ch.channel] <= WIDTH_BITS'(edge_delta);
                end
            end
            else
            begin
                received_reg  <= rise_seen_reg;
                rise_seen_reg <= '0;
            end
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_accept) state_next = ST_START0;
            ST_START0: state_next = ST_WAIT0;
            ST_WAIT0:  if (div_res.done) state_next = ST_START1;
            ST_START1: state_next = ST_WAIT1;
            ST_WAIT1:  if (div_res.done) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = 1'b0;
        div_start   = 1'b0;
        sel         = 1'b0;
        cmd_store   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ch.ready = 1'b1;
            ST_START0: div_start = 1'b1;
            ST_WAIT0:  cmd_store = div_res.done;
            ST_START1:
            begin
                div_start = 1'b1;
                sel       = 1'b1;
            end
            ST_WAIT1:
            begin
                sel       = 1'b1;
                cmd_store = div_res.done;
            end
            ST_DONE:   out_load = !out_valid_reg || out_ch.ready;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- command
    assign sel_width = pulse_width_reg[sel];
    assign sel_recv  = received_reg[sel];
    assign sel_fs    = sel_width < failsafe_reg;
    assign in_window = (sel_width >= min_width_reg) && (sel_width <= max_width_reg);
    assign x_width   = in_window ? sel_width : '0;
    assign den       = map_high_reg - map_low_reg;
    assign den_ok    = map_high_reg > map_low_reg;
    assign num_pos   = x_width >= map_low_reg;
    assign num_diff  = x_width - map_low_reg;
    // Adding half the divisor before truncating division rounds to nearest.
    assign dividend  = {1'b0, num_diff, FRAC_SHIFT'(0)} + DIVIDEND_BITS'(den >> 1);

    rcpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den),
        .result   (div_res)
    );

    assign q_mag = (div_res.ovf || (div_res.quot > QUOT_BITS'(Q_SPAN)))
                   ? Q_SPAN : div_res.quot[WIDTH_BITS-1:0];
    assign q_val = signed'(q_mag - Q_ONE);

    // A negative numerator always lands at or below minus one, so it clamps.
    always_comb
    begin
        if (sel_fs || !sel_recv || !den_ok)
        begin
            cmd = '0;
        end
        else if (!num_pos)
        begin
            cmd = -signed'(Q_ONE);
        end
        else
        begin
            cmd = q_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_store)
        begin
            cmd_reg[sel] <= cmd;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.throttle     <= cmd_reg[0];
            out_ch.steer        <= cmd_reg[1];
            out_ch.present_one  <= received_reg[0];
            out_ch.present_two  <= received_reg[1];
            out_ch.failsafe_one <= pulse_width_reg[0] < failsafe_reg;
            out_ch.failsafe_two <= pulse_width_reg[1] < failsafe_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

    // ---------------------------------------------------------------- checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ch.ready)
        else $error("input accepted again while an item is in flight");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_WAIT0 || state_reg == ST_WAIT1))
        else $error("divider finished outside a wait state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without completing both channels");

    a_failsafe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.failsafe_one) |-> out_ch.throttle == 16'sd0)
        else $error("throttle nonzero while channel one is in failsafe");

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ch.steer <= 16'sd16384 && out_ch.steer >= -16'sd16384))
        else $error("steer command outside plus or minus one");

endmodule
